// File: rtl/lssr_pkg.sv
// Shared types and constants for the line-scan sensor readout sequencer.
package lssr_pkg;

   localparam int LINE_PIXELS_DEF = 128;

   localparam int ADC_W       = 12;
   localparam int EXP_W       = 32;
   localparam int PIX_CFG_W   = 7;
   localparam int STEP_CFG_W  = 5;
   localparam int STEP_CNT_W  = 4;
   localparam int SAMPLE_IX_W = 7;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [EXP_W-1:0]      EXPOSURE_TICKS_RST  = 32'd300000;
   localparam logic [PIX_CFG_W-1:0]  EXPOSURE_START_RST  = 7'd18;
   localparam logic [PIX_CFG_W-1:0]  WINDOW_MARGIN_RST   = 7'd34;
   localparam logic [STEP_CFG_W-1:0] DECIMATION_STEP_RST = 5'd3;
   localparam logic [ADC_W-1:0]      THRESHOLD_RST       = 12'd2500;

   localparam logic [STEP_CFG_W-1:0] STEP_MIN = 5'd1;
   localparam logic [STEP_CFG_W-1:0] STEP_MAX = 5'd16;

   localparam logic [CSR_IDX_W-1:0] REG_EXPOSURE_TICKS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EXPOSURE_START  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_MARGIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DECIMATION_STEP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD       = 3'd4;

   typedef enum logic [1:0] {
      PH_INTEGRATE = 2'd0,
      PH_EXPOSE    = 2'd1,
      PH_CAPTURE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      HALF_SETUP = 2'd0,
      HALF_HIGH  = 2'd1,
      HALF_LOW   = 2'd2
   } half_type;

endpackage

// File: rtl/line_scan_sensor_readout_top.sv
// Line-scan sensor readout sequencer: SI/CLK timing, exposure timer, sampling.
//
//   channel  dir  handshake                content
//   req      in   req_tvalid/req_tready    adc reading, one beat per tick
//   rsp      out  rsp_tvalid/rsp_tready    pin levels, sample, line end
//   csr      in   csr_valid/csr_ready      register index and write data
//
// Every req beat yields exactly one rsp beat. A beat is processed in the
// cycle it is accepted and its result sits in the rsp register next cycle:
// one beat per clock unless rsp stalls. req_tready stays high while the rsp
// register is empty or being drained, so rsp stalls pass straight back to req.
// Reset (synchronous) restores the register defaults and starts an integrate scan.
module line_scan_sensor_readout_top
   import lssr_pkg::*;
#(
   parameter int LINE_PIXELS = LINE_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] adc_sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] si_level, [1] clk_level, [2] sample_valid, [9:3] sample_index,
   // [21:10] sample_value, [22] above_threshold, [23] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // line_done
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PIX_W = $clog2(LINE_PIXELS);
   localparam int CMP_W = ((PIX_W > PIX_CFG_W) ? PIX_W : PIX_CFG_W) + 1;
   localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(LINE_PIXELS - 1);
   localparam logic [CMP_W-1:0] LINE_LEN = CMP_W'(LINE_PIXELS);

   // configuration
   logic [EXP_W-1:0]      exp_ticks_ff;
   logic [PIX_CFG_W-1:0]  exp_start_ff;
   logic [PIX_CFG_W-1:0]  margin_ff;
   logic [STEP_CFG_W-1:0] step_cfg_ff;
   logic [ADC_W-1:0]      threshold_ff;

   // sequencer state
   phase_type              phase_ff, phase_in;
   half_type               half_ff, half_in;
   logic [PIX_W-1:0]       pixel_ff, pixel_in;
   logic [EXP_W-1:0]       counter_ff, counter_in, counter_base;
   logic                   running_ff, running_in;
   logic [SAMPLE_IX_W-1:0] scount_ff, scount_in;
   logic [STEP_CNT_W-1:0]  step_ff, step_in;
   logic                   started;

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic [ADC_W-1:0]       adc;
   logic [CMP_W-1:0]       pix_ext, margin_ext, start_ext;
   logic                   in_window, at_margin, take, last_pix, high_capture;
   logic [STEP_CFG_W-1:0]  step_eff, sc_next;
   logic [STEP_CNT_W-1:0]  sc;
   logic                   si, clk_lvl, s_valid, s_above;
   logic [SAMPLE_IX_W-1:0] s_index;
   logic [ADC_W-1:0]       s_value;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign adc        = req_tdata[ADC_W-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ticks_ff <= EXPOSURE_TICKS_RST;
         exp_start_ff <= EXPOSURE_START_RST;
         margin_ff    <= WINDOW_MARGIN_RST;
         step_cfg_ff  <= DECIMATION_STEP_RST;
         threshold_ff <= THRESHOLD_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_EXPOSURE_TICKS:  exp_ticks_ff <= csr_data;
            REG_EXPOSURE_START:  exp_start_ff <= csr_data[PIX_CFG_W-1:0];
            REG_WINDOW_MARGIN:   margin_ff    <= csr_data[PIX_CFG_W-1:0];
            REG_DECIMATION_STEP: step_cfg_ff  <= csr_data[STEP_CFG_W-1:0];
            REG_THRESHOLD:       threshold_ff <= csr_data[ADC_W-1:0];
            default: ;
         endcase
      end
   end

   // pixel window and decimation
   assign pix_ext      = CMP_W'(pixel_ff);
   assign margin_ext   = CMP_W'(margin_ff);
   assign start_ext    = CMP_W'(exp_start_ff);
   assign in_window    = (pix_ext >= margin_ext) && ((pix_ext + margin_ext) <= LINE_LEN);
   assign at_margin    = (pix_ext == margin_ext);
   assign sc           = at_margin ? '0 : step_ff;
   assign take         = (sc == '0);
   assign last_pix     = (pixel_ff == LAST_PIX);
   assign high_capture = (phase_ff == PH_CAPTURE) && (half_ff == HALF_HIGH);

   always_comb begin
      if (step_cfg_ff < STEP_MIN) begin
         step_eff = STEP_MIN;
      end else if (step_cfg_ff > STEP_MAX) begin
         step_eff = STEP_MAX;
      end else begin
         step_eff = step_cfg_ff;
      end
   end

   assign sc_next = STEP_CFG_W'(sc) + STEP_CFG_W'(1);

   // next state
   always_comb begin
      phase_in     = phase_ff;
      half_in      = half_ff;
      pixel_in     = pixel_ff;
      counter_base = counter_ff;
      running_in   = running_ff;
      scount_in    = scount_ff;
      step_in      = step_ff;
      started      = 1'b0;
      unique case (phase_ff)
         PH_EXPOSE: begin
            if (counter_ff >= exp_ticks_ff) begin
               running_in = 1'b0;
               phase_in   = PH_CAPTURE;
               pixel_in   = '0;
               half_in    = HALF_SETUP;
            end
         end
         PH_INTEGRATE, PH_CAPTURE: begin
            unique case (half_ff)
               HALF_SETUP: begin
                  if (phase_ff == PH_CAPTURE) begin
                     scount_in = '0;
                     step_in   = '0;
                  end
                  half_in = HALF_HIGH;
               end
               HALF_HIGH: begin
                  if (phase_ff == PH_INTEGRATE && pix_ext == start_ext) begin
                     counter_base = '0;
                     running_in   = 1'b1;
                     started      = 1'b1;
                  end
                  if (phase_ff == PH_CAPTURE && in_window) begin
                     if (take) begin
                        scount_in = scount_ff + SAMPLE_IX_W'(1);
                     end
                     step_in = (sc_next >= step_eff) ? '0 : sc_next[STEP_CNT_W-1:0];
                  end
                  half_in = HALF_LOW;
               end
               default: begin
                  if (last_pix) begin
                     pixel_in = '0;
                     half_in  = HALF_SETUP;
                     if (phase_ff == PH_INTEGRATE) begin
                        phase_in = PH_EXPOSE;
                        if (!running_ff) begin
                           counter_base = '0;
                           running_in   = 1'b1;
                           started      = 1'b1;
                        end
                     end else begin
                        phase_in = PH_INTEGRATE;
                     end
                  end else begin
                     pixel_in = pixel_ff + PIX_W'(1);
                     half_in  = HALF_HIGH;
                  end
               end
            endcase
         end
         default: begin
            phase_in = PH_INTEGRATE;
            pixel_in = '0;
            half_in  = HALF_SETUP;
         end
      endcase
      counter_in = counter_base;
      if (running_ff && running_in && !started && (counter_base != '1)) begin
         counter_in = counter_base + EXP_W'(1);
      end
   end

   // tick outputs
   always_comb begin
      si      = 1'b0;
      clk_lvl = 1'b0;
      if (phase_ff == PH_INTEGRATE || phase_ff == PH_CAPTURE) begin
         unique case (half_ff)
            HALF_SETUP: si = 1'b1;
            HALF_HIGH: begin
               clk_lvl = 1'b1;
               si      = (pixel_ff == '0);
            end
            default: ;
         endcase
      end
      s_valid = high_capture && in_window && take;
      s_index = s_valid ? scount_ff : '0;
      s_value = s_valid ? adc : '0;
      s_above = s_valid && (adc > threshold_ff);
      rsp_data_in = {1'b0, s_above, s_value, s_index, s_valid, clk_lvl, si};
      rsp_last_in = high_capture && last_pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_INTEGRATE;
         half_ff      <= HALF_SETUP;
         pixel_ff     <= '0;
         counter_ff   <= '0;
         running_ff   <= 1'b0;
         scount_ff    <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            half_ff    <= half_in;
            pixel_ff   <= pixel_in;
            counter_ff <= counter_in;
            running_ff <= running_in;
            scount_ff  <= scount_in;
            step_ff    <= step_in;
         end
         if (req_tready) begin
            rsp_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule
